/* hdl/dfs_pkg.sv */
// Shared types, constants and helpers of the delimited field splitter.
// No dependencies; every other file imports this package.
package dfs_pkg;

  // Field length limit and delimiter size
  localparam int unsigned MAX_FIELD_BYTES = 1024;
  localparam int unsigned MAX_DELIM_BYTES = 8;
  localparam int unsigned FLEN_W          = $clog2(MAX_FIELD_BYTES);
  localparam logic [FLEN_W-1:0] FLEN_LIMIT = FLEN_W'(MAX_FIELD_BYTES - 1);

  // Held-byte count and byte index into the 64-bit delimiter word
  localparam int unsigned MC_W   = 3;
  localparam int unsigned DLEN_W = 4;
  localparam logic [DLEN_W-1:0] DLEN_MAX = DLEN_W'(MAX_DELIM_BYTES);

  // Command queue between front and back
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FIELD  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_FIELD   = 4'd3;

  localparam logic [15:0] FIELD_OPEN = 16'hFFFF;

  // Final result of a command, after any released held bytes
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_DATA = 2'd1,
    TAIL_DONE = 2'd2,
    TAIL_ERR  = 2'd3
  } tail_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  out_byte;
    logic [15:0] field_number;
    logic        field_done;
    logic        too_long;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [63:0]       delim_bytes;
    logic [DLEN_W-1:0] delim_length;
    logic [15:0]       first_field;
    logic [15:0]       last_field;
  } cfg_t;

  // One command expands into rel_cnt released bytes, then the tail result
  typedef struct packed {
    logic [15:0]     field_number;
    logic [MC_W-1:0] rel_cnt;
    tail_e           tail;
    logic [7:0]      data_byte;
  } cmd_t;

  function automatic logic [7:0] delim_byte(input logic [63:0] d, input logic [MC_W-1:0] i);
    delim_byte = d[{i, 3'b000} +: 8];
  endfunction

endpackage

/* hdl/delimited_field_splitter_core.sv */
// Top level of the delimited field splitter: configuration registers,
// front, command queue and back. Depends on dfs_pkg and the dfs_* modules.
//
// Usage:
//   Input channel: push/full with in_item_i (data_byte, end_of_input). An item
//   is taken at a clock edge with push high and full low.
//   Result channel: empty/pop with out_item_o; the oldest result is shown while
//   empty is low and is taken at an edge with pop high.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (0 delimiter bytes, 1 delimiter length, 2 first field, 3 last field);
//   other indexes are ignored. Write only while the block is idle.
// Flow:
//   Each item's command passes through the command queue and then the
//   registered result stage. That stage hands out one result per cycle while
//   the receiver takes them; an item has one to eight results, and items
//   with no result never enter it. The front takes one item per cycle while the
//   four-entry command queue has room.
// Reset clears the field state, the error flag and the queue and loads the
// default configuration. When the receiver stalls, the result holds, the
// queue fills and full rises; nothing is lost.
module delimited_field_splitter_core import dfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_wdata_i,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_item_o
);

  cfg_t cfg_q;
  logic cmd_valid;
  cmd_t cmd;
  logic q_full;
  logic head_valid;
  cmd_t head;
  logic head_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim_bytes  <= 64'h0000_0000_0020_2D20;
      cfg_q.delim_length <= DLEN_W'(3);
      cfg_q.first_field  <= 16'd1;
      cfg_q.last_field   <= 16'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DELIM_BYTES:  cfg_q.delim_bytes  <= cfg_wdata_i;
        CFG_DELIM_LENGTH: cfg_q.delim_length <= cfg_wdata_i[DLEN_W-1:0];
        CFG_FIRST_FIELD:  cfg_q.first_field  <= cfg_wdata_i[15:0];
        CFG_LAST_FIELD:   cfg_q.last_field   <= cfg_wdata_i[15:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  dfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  dfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .valid_o (head_valid),
    .head_o  (head),
    .pop_i   (head_pop)
  );

  dfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delim_bytes_i (cfg_q.delim_bytes),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .head_pop_o    (head_pop),
    .empty         (empty),
    .pop           (pop),
    .out_item_o    (out_item_o)
  );

endmodule

/* hdl/dfs_front.sv */
// Front part: accepts bytes, tracks delimiter match and field state,
// and issues at most one result command per item. Depends on dfs_pkg.
module dfs_front import dfs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o
);

  logic [MC_W-1:0]   mc_q, mc_d;
  logic [15:0]       fc_q, fc_d;
  logic [FLEN_W-1:0] fl_q, fl_d;
  logic              err_q, err_d;

  logic              accept;
  logic [DLEN_W-1:0] len;
  logic              sel;
  logic              fl_full;
  logic              match;
  logic [15:0]       fc_inc;
  logic [MC_W-1:0]   rel_mc;
  cmd_t              cmd;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;

  // Clamp the delimiter length to 1..MAX_DELIM_BYTES
  always_comb begin
    if (cfg_i.delim_length == '0) begin
      len = DLEN_W'(1);
    end else if (cfg_i.delim_length > DLEN_MAX) begin
      len = DLEN_MAX;
    end else begin
      len = cfg_i.delim_length;
    end
  end

  assign sel = (fc_q >= cfg_i.first_field) &&
               ((cfg_i.last_field == FIELD_OPEN) || (fc_q <= cfg_i.last_field));
  assign fl_full = (fl_q >= FLEN_LIMIT);
  assign match   = ({1'b0, mc_q} < len) &&
                   (in_item_i.data_byte == delim_byte(cfg_i.delim_bytes, mc_q));
  assign fc_inc  = (fc_q != FIELD_OPEN) ? fc_q + 16'd1 : fc_q;
  assign rel_mc  = sel ? mc_q : '0;

  // Classify the item and compute the next field state
  always_comb begin
    mc_d  = mc_q;
    fc_d  = fc_q;
    fl_d  = fl_q;
    err_d = err_q;
    cmd.field_number = fc_q;
    cmd.rel_cnt      = '0;
    cmd.tail         = TAIL_NONE;
    cmd.data_byte    = in_item_i.data_byte;
    priority if (err_q) begin
      cmd.tail = TAIL_ERR;
    end else if (in_item_i.end_of_input) begin
      cmd.rel_cnt = rel_mc;
      if ((fl_q != '0) && sel) cmd.tail = TAIL_DONE;
      fc_d = 16'd1;
      fl_d = '0;
      mc_d = '0;
    end else if (match) begin
      if ({1'b0, mc_q} + DLEN_W'(1) == len) begin
        if (sel) cmd.tail = TAIL_DONE;
        fc_d = fc_inc;
        fl_d = '0;
        mc_d = '0;
      end else if (fl_full) begin
        err_d    = 1'b1;
        cmd.tail = TAIL_ERR;
      end else begin
        fl_d = fl_q + FLEN_W'(1);
        mc_d = mc_q + MC_W'(1);
      end
    end else begin
      // Release held bytes, then retest against the first delimiter byte
      cmd.rel_cnt = rel_mc;
      mc_d        = '0;
      if (in_item_i.data_byte == delim_byte(cfg_i.delim_bytes, '0)) begin
        if (len == DLEN_W'(1)) begin
          if (sel) cmd.tail = TAIL_DONE;
          fc_d = fc_inc;
          fl_d = '0;
        end else if (fl_full) begin
          err_d    = 1'b1;
          cmd.tail = TAIL_ERR;
        end else begin
          fl_d = fl_q + FLEN_W'(1);
          mc_d = MC_W'(1);
        end
      end else if (fl_full) begin
        err_d    = 1'b1;
        cmd.tail = TAIL_ERR;
      end else begin
        fl_d = fl_q + FLEN_W'(1);
        if (sel) cmd.tail = TAIL_DATA;
      end
    end
  end

  // Drop commands that yield no result
  assign cmd_valid_o = accept && ((cmd.rel_cnt != '0) || (cmd.tail != TAIL_NONE));
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q  <= '0;
      fc_q  <= 16'd1;
      fl_q  <= '0;
      err_q <= 1'b0;
    end else if (accept) begin
      mc_q  <= mc_d;
      fc_q  <= fc_d;
      fl_q  <= fl_d;
      err_q <= err_d;
    end
  end

`ifndef ASSERT_OFF
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q) else $error("error flag cleared");
  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fl_q <= FLEN_LIMIT) else $error("field length past limit");
  a_err_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && err_q) |-> (cmd_valid_o && cmd_o.tail == TAIL_ERR && cmd_o.rel_cnt == '0))
    else $error("error state item without single error result");
`endif

endmodule

/* hdl/dfs_queue.sv */
// Short command queue that decouples the front and back parts.
// Depends on dfs_pkg.
module dfs_queue import dfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("push into full queue");
`endif

endmodule

/* hdl/dfs_back.sv */
// Back part: expands each command into result items, one per cycle while
// the receiver takes them, into a registered output stage. Depends on dfs_pkg.
module dfs_back import dfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] delim_bytes_i,
  input  logic        head_valid_i,
  input  cmd_t        head_i,
  output logic        head_pop_o,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o
);

  logic [MC_W-1:0]   idx_q, idx_d;
  logic              valid_q;
  out_item_t         res_q;
  out_item_t         res;
  logic [MC_W:0]     total;
  logic              is_last;
  logic              load;

  assign total   = {1'b0, head_i.rel_cnt} + ((head_i.tail != TAIL_NONE) ? 4'd1 : 4'd0);
  assign is_last = ({1'b0, idx_q} + 4'd1 == total);
  assign load    = head_valid_i && (!valid_q || pop);

  // Build the result at the current position of the command
  always_comb begin
    res.has_byte     = 1'b0;
    res.out_byte     = 8'd0;
    res.field_number = head_i.field_number;
    res.field_done   = 1'b0;
    res.too_long     = 1'b0;
    res.last_result  = is_last;
    if (idx_q < head_i.rel_cnt) begin
      res.has_byte = 1'b1;
      res.out_byte = delim_byte(delim_bytes_i, idx_q);
    end else begin
      unique case (head_i.tail)
        TAIL_DATA: begin
          res.has_byte = 1'b1;
          res.out_byte = head_i.data_byte;
        end
        TAIL_DONE: res.field_done = 1'b1;
        TAIL_ERR:  res.too_long   = 1'b1;
        default:   res.has_byte   = 1'b0;
      endcase
    end
  end

  assign head_pop_o = load && is_last;
  assign idx_d      = load ? (is_last ? '0 : idx_q + MC_W'(1)) : idx_q;
  assign empty      = !valid_q;
  assign out_item_o = res_q;

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (load) res_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (pop) begin
        valid_q <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop_o |-> head_valid_i) else $error("pop of empty queue");
  a_rest_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_q.last_result) |-> (head_valid_i && idx_q != '0))
    else $error("command dropped before its last result");
`endif

endmodule
